// ===== rtl/core/tdc_pkg.sv =====
// Package for the fan curve lookup: sizes, state encoding and codes.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package tdc_pkg;

  localparam int MAX_POINTS = 16;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int TEMP_W     = 16;
  localparam int DUTY_W     = 15;
  localparam int ENTRY_W    = TEMP_W + DUTY_W;
  localparam int COUNT_W    = 5;
  localparam int STEP_W     = 4;
  localparam int PROD_W     = 32;

  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(15);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DUTY_W - 1);

  localparam logic [15:0]        GAIN_RESET   = 16'd4096;
  localparam logic [15:0]        OFFSET_RESET = 16'd0;
  localparam logic [COUNT_W-1:0] COUNT_RESET  = COUNT_W'(1);

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [1:0] STATUS_WRITE  = 2'd0;
  localparam logic [1:0] STATUS_CLAMP  = 2'd1;
  localparam logic [1:0] STATUS_INTERP = 2'd2;

  localparam logic [1:0] CFG_GAIN   = 2'd0;
  localparam logic [1:0] CFG_OFFSET = 2'd1;
  localparam logic [1:0] CFG_COUNT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SAT,
    ST_CMP,
    ST_MULD,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tdc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/temp_to_duty_curve_interp_top.sv =====
// Fan curve lookup top level: bit-serial calibration, point search, serial
// interpolation. Depends on tdc_pkg and tdc_ram.
//
// channel  | handshake        | word
// ---------+------------------+--------------------------------------------------
// request  | start / busy     | req_type, temperature, point_index, point_temp,
//          |                  | point_duty
// result   | done (strobe)    | duty, calibrated_temp, segment, status
// config   | cfg_we           | cfg_index, cfg_data
//
// A write word answers in the cycle after it is taken; busy stays low.
// A sample runs shift-add calibration, a saturation step and a point search that
// reads one curve point at a time from the point RAM (1 to MAX_POINTS). An
// interpolated sample adds a shift-add multiply, a restoring division and a
// final add. Reset clears the state, done, the step and search counters and the
// settings; result and datapath registers and curve points are not cleared.
// done is high for one cycle per word; the receiver cannot stall it.
`default_nettype none

module temp_to_duty_curve_interp_top
  import tdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               req_type,
  input  wire logic signed [15:0] temperature,
  input  wire logic [3:0]         point_index,
  input  wire logic signed [15:0] point_temp,
  input  wire logic [14:0]        point_duty,
  output logic                    done,
  output logic [14:0]             duty,
  output logic signed [15:0]      calibrated_temp,
  output logic [3:0]              segment,
  output logic [1:0]              status,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  state_t state, state_next;

  logic [15:0]        temp_gain;
  logic [15:0]        temp_bias;
  logic [COUNT_W-1:0] point_count;

  logic [STEP_W-1:0]  step;
  logic               done_next;

  logic [PROD_W-1:0]  mcand;
  logic [15:0]        mplier;
  logic [PROD_W-1:0]  acc;
  logic [PROD_W-1:0]  term;
  logic [PROD_W-1:0]  acc_sum;

  logic signed [15:0] tcal;
  logic [ADDR_W-1:0]  k, k_next, last;
  logic signed [15:0] prev_temp;
  logic [DUTY_W-1:0]  prev_duty;
  logic [15:0]        dt;
  logic               neg;
  logic [15:0]        rem;
  logic [DUTY_W-1:0]  quo;

  logic               accept, is_write, ram_we;
  logic [ENTRY_W-1:0] rdata;
  logic signed [15:0] rd_temp;
  logic [DUTY_W-1:0]  rd_duty;
  logic               below, equal, at_last, first, finish_clamp, interp, advance;
  logic [ADDR_W-1:0]  last_of;

  logic signed [19:0] q;
  logic signed [20:0] s;
  logic signed [15:0] s_sat;

  logic signed [15:0] dd;
  logic [15:0]        mag;
  logic signed [16:0] dtt;
  logic signed [16:0] dt_full;

  logic [16:0]        r2;
  logic [16:0]        r2_diff;
  logic               ge;
  logic [DUTY_W-1:0]  adj;

  assign accept   = start && !busy;
  assign is_write = (req_type == REQ_WRITE);
  assign ram_we   = accept && is_write && (32'(point_index) < 32'(MAX_POINTS));

  tdc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(point_index)),
    .wdata ({point_temp, point_duty}),
    .raddr (k_next),
    .rdata (rdata)
  );

  assign rd_temp = rdata[ENTRY_W-1:DUTY_W];
  assign rd_duty = rdata[DUTY_W-1:0];

  assign last_of = (point_count == '0) ? '0 :
                   (32'(point_count) > 32'(MAX_POINTS)) ? ADDR_W'(MAX_POINTS - 1) :
                   ADDR_W'(point_count - 1'b1);

  // search decode
  assign first   = (k == '0);
  assign below   = rd_temp < tcal;
  assign equal   = rd_temp == tcal;
  assign at_last = (k == last);
  always_comb begin
    if (first) begin
      finish_clamp = !below || at_last;
      interp       = 1'b0;
      advance      = below && !at_last;
    end else begin
      finish_clamp = below ? at_last : equal;
      interp       = !below && !equal;
      advance      = below && !at_last;
    end
  end

  // shared shift-add multiplier
  assign term    = (state == ST_MUL && step == MUL_LAST) ? (~mcand + 1'b1) : mcand;
  assign acc_sum = mplier[0] ? (acc + term) : acc;

  // saturation of calibrated value
  assign q = acc[PROD_W-1:12];
  assign s = {q[19], q} + {{5{temp_bias[15]}}, temp_bias};
  always_comb begin
    if (s > 21'sd32767) begin
      s_sat = 16'sh7fff;
    end else if (s < -21'sd32768) begin
      s_sat = -16'sh8000;
    end else begin
      s_sat = s[15:0];
    end
  end

  // interpolation setup
  assign dd      = $signed({1'b0, rd_duty}) - $signed({1'b0, prev_duty});
  assign mag     = dd[15] ? (~dd + 1'b1) : dd;
  assign dtt     = {tcal[15], tcal} - {prev_temp[15], prev_temp};
  assign dt_full = {rd_temp[15], rd_temp} - {prev_temp[15], prev_temp};

  // restoring division step
  assign r2      = {rem, quo[DUTY_W-1]};
  assign r2_diff = r2 - {1'b0, dt};
  assign ge      = !r2_diff[16];
  assign adj     = neg ? (~quo + 1'b1) : quo;

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    k_next     = k;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_write) begin
            done_next = 1'b1;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (step == MUL_LAST) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT: begin
        k_next     = '0;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (finish_clamp) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (interp) begin
          state_next = ST_MULD;
        end else if (advance) begin
          k_next = ADDR_W'(k + 1'b1);
        end
      end
      ST_MULD: begin
        if (step == MUL_LAST) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step == DIV_LAST) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      step        <= '0;
      k           <= '0;
      temp_gain   <= GAIN_RESET;
      temp_bias   <= OFFSET_RESET;
      point_count <= COUNT_RESET;
    end else begin
      done <= done_next;
      k    <= k_next;
      step <= (state_next != state) ? '0 : STEP_W'(step + 1'b1);
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:   temp_gain   <= cfg_data;
          CFG_OFFSET: temp_bias   <= cfg_data;
          CFG_COUNT:  point_count <= cfg_data[COUNT_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_write) begin
            duty            <= '0;
            calibrated_temp <= '0;
            segment         <= point_index;
            status          <= STATUS_WRITE;
          end else begin
            mcand  <= {{(PROD_W-16){temperature[15]}}, temperature};
            mplier <= temp_gain;
            acc    <= '0;
            last   <= last_of;
          end
        end
      end
      ST_MUL, ST_MULD: begin
        acc    <= acc_sum;
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[15:1]};
        if (state == ST_MULD && step == MUL_LAST) begin
          rem <= acc_sum[PROD_W-2:DUTY_W];
          quo <= acc_sum[DUTY_W-1:0];
        end
      end
      ST_SAT: begin
        tcal <= s_sat;
      end
      ST_CMP: begin
        if (finish_clamp) begin
          duty            <= rd_duty;
          calibrated_temp <= tcal;
          segment         <= 4'(k);
          status          <= STATUS_CLAMP;
        end else if (interp) begin
          neg     <= dd[15];
          dt      <= dt_full[15:0];
          mcand   <= {{(PROD_W-16){1'b0}}, mag};
          mplier  <= dtt[15:0];
          acc     <= '0;
          segment <= 4'(k);
        end else begin
          prev_temp <= rd_temp;
          prev_duty <= rd_duty;
        end
      end
      ST_DIV: begin
        rem <= ge ? r2_diff[15:0] : r2[15:0];
        quo <= {quo[DUTY_W-2:0], ge};
      end
      ST_FIN: begin
        duty            <= DUTY_W'(prev_duty + adj);
        calibrated_temp <= tcal;
        status          <= STATUS_INTERP;
      end
      default: ;
    endcase
  end

  a_done_follows_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result strobe without a request in progress");

  a_write_result_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_WRITE) |-> (duty == '0 && calibrated_temp == '0))
    else $error("write answer carries nonzero duty or temperature");

  a_search_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (k <= last))
    else $error("point search beyond the last active point");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_SAMPLE) |=> (busy && !done))
    else $error("sample not held busy");

endmodule

`default_nettype wire

// ===== bench/tb_temp_to_duty_curve_interp_top.sv =====
// Testbench for the fan curve lookup: loads curve points, sweeps calibration settings
// and point counts, and checks every duty word against a built-in lookup predictor.
// Depends on tdc_pkg and temp_to_duty_curve_interp_top.
`timescale 1ns / 1ps

module tb_temp_to_duty_curve_interp_top;
  import tdc_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1800;
  localparam int TAIL_CYCLES  = 90;

  typedef enum logic [1:0] {OP_WORD, OP_SETTING, OP_PAUSE} op_kind_t;

  typedef struct {
    op_kind_t                 kind;
    logic                     req;
    logic signed [15:0]       temp;
    logic [3:0]               idx;
    logic signed [15:0]       ptemp;
    logic [14:0]              pduty;
    logic [1:0]               reg_sel;
    logic [15:0]              reg_val;
    bit                       eager;
  } fan_op_t;

  typedef struct {
    logic [14:0]        duty;
    logic signed [15:0] cal;
    logic [3:0]         seg;
    logic [1:0]         status;
  } fan_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                req_type = 1'b0;
  logic signed [15:0]  temperature = '0;
  logic [3:0]          point_index = '0;
  logic signed [15:0]  point_temp = '0;
  logic [14:0]         point_duty = '0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;
  logic                busy;
  logic                done;
  logic [14:0]         duty;
  logic signed [15:0]  calibrated_temp;
  logic [3:0]          segment;
  logic [1:0]          status;

  temp_to_duty_curve_interp_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .temperature(temperature), .point_index(point_index), .point_temp(point_temp),
    .point_duty(point_duty), .done(done), .duty(duty), .calibrated_temp(calibrated_temp),
    .segment(segment), .status(status), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  fan_op_t     request_backlog[$];
  fan_result_t expected_lookups[$];

  // predictor state
  logic signed [15:0] cal_gain;
  logic signed [15:0] cal_offset;
  logic [4:0]         active_points;
  logic signed [15:0] curve_temp[MAX_POINTS];
  logic [14:0]        curve_duty[MAX_POINTS];

  // stimulus planning shadow
  int  plan_temp[MAX_POINTS];
  int  plan_gain = 4096;
  int  plan_offset = 0;
  int  plan_count = 1;
  bit  eager_mode = 1'b0;
  int  word_count = 0;

  int  errors = 0;
  int  quiet_cycles = 0;
  int  setting_writes = 0;
  int  seen_writes = 0;
  int  seen_clamped = 0;
  int  seen_interp = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic fan_result_t lookup_duty(input logic rt, input logic signed [15:0] t_in,
                                              input logic [3:0] idx,
                                              input logic signed [15:0] pt,
                                              input logic [14:0] pd);
    fan_result_t r;
    longint prod, t, t0, t1, d0, d1, d;
    int n, i;
    r.duty = '0;
    r.cal = '0;
    r.seg = idx;
    r.status = STATUS_WRITE;
    if (rt == REQ_WRITE) begin
      curve_temp[idx] = pt;
      curve_duty[idx] = pd;
      return r;
    end
    prod = longint'(t_in) * longint'(cal_gain);
    t = (prod >>> 12) + longint'(cal_offset);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    r.cal = 16'(t);
    n = (active_points == 0) ? 1 : (active_points > MAX_POINTS) ? MAX_POINTS :
        int'(active_points);
    r.status = STATUS_CLAMP;
    if (t <= longint'(curve_temp[0])) begin
      r.duty = curve_duty[0];
      r.seg = '0;
    end else begin
      i = 1;
      while (i < n && longint'(curve_temp[i]) < t) i++;
      if (i >= n) begin
        r.seg = 4'(n - 1);
        r.duty = curve_duty[n - 1];
      end else if (t >= longint'(curve_temp[i])) begin
        r.seg = 4'(i);
        r.duty = curve_duty[i];
      end else begin
        t0 = curve_temp[i - 1];
        t1 = curve_temp[i];
        d0 = curve_duty[i - 1];
        d1 = curve_duty[i];
        d = d0 + ((d1 - d0) * (t - t0)) / (t1 - t0);
        r.duty = 15'(d);
        r.seg = 4'(i);
        r.status = STATUS_INTERP;
      end
    end
    return r;
  endfunction

  function automatic void store_setting(input logic [1:0] sel, input logic [15:0] val);
    case (sel)
      CFG_GAIN:   cal_gain = val;
      CFG_OFFSET: cal_offset = val;
      CFG_COUNT:  active_points = val[4:0];
      default: ;
    endcase
  endfunction

  function automatic void push_item(input logic rt, input logic signed [15:0] t,
                                    input logic [3:0] idx, input logic signed [15:0] pt,
                                    input logic [14:0] pd);
    fan_op_t op;
    op.kind = OP_WORD;
    op.req = rt;
    op.temp = t;
    op.idx = idx;
    op.ptemp = pt;
    op.pduty = pd;
    op.reg_sel = '0;
    op.reg_val = '0;
    op.eager = eager_mode;
    if (rt == REQ_WRITE) plan_temp[idx] = pt;
    word_count++;
    request_backlog.push_back(op);
  endfunction

  function automatic void push_write(input int idx, input longint pt, input int pd);
    push_item(REQ_WRITE, 16'($urandom), 4'(idx), sat16(pt), 15'(pd));
  endfunction

  function automatic void push_sample(input logic signed [15:0] t);
    push_item(REQ_SAMPLE, t, 4'($urandom), 16'($urandom), 15'($urandom));
  endfunction

  function automatic void queue_setting(input logic [1:0] sel, input logic [15:0] val);
    fan_op_t op;
    op.kind = OP_SETTING;
    op.req = REQ_WRITE;
    op.temp = '0;
    op.idx = '0;
    op.ptemp = '0;
    op.pduty = '0;
    op.reg_sel = sel;
    op.reg_val = val;
    op.eager = 1'b0;
    case (sel)
      CFG_GAIN:   plan_gain = int'($signed(val));
      CFG_OFFSET: plan_offset = int'($signed(val));
      CFG_COUNT:  plan_count = int'(val[4:0]);
      default: ;
    endcase
    request_backlog.push_back(op);
  endfunction

  function automatic void queue_pause();
    fan_op_t op;
    op.kind = OP_PAUSE;
    op.req = REQ_WRITE;
    op.temp = '0;
    op.idx = '0;
    op.ptemp = '0;
    op.pduty = '0;
    op.reg_sel = '0;
    op.reg_val = '0;
    op.eager = 1'b0;
    request_backlog.push_back(op);
  endfunction

  // invert the calibration so the calibrated value lands near target
  function automatic logic signed [15:0] aim_at(input int target);
    if (plan_gain == 0) return 16'($urandom);
    return sat16(((longint'(target) - plan_offset) * 4096) / plan_gain);
  endfunction

  function automatic logic signed [15:0] pick_sample();
    int n, k, lo, hi, roll;
    n = (plan_count == 0) ? 1 : (plan_count > MAX_POINTS) ? MAX_POINTS : plan_count;
    roll = $urandom_range(99);
    if (roll < 30) return 16'($urandom);
    if (roll < 75 && n > 1) begin
      k = $urandom_range(n - 1, 1);
      lo = plan_temp[k - 1];
      hi = plan_temp[k];
      if (lo < hi) return aim_at(lo + int'($urandom_range(hi - lo)));
      return aim_at(lo);
    end
    if (roll < 90) return aim_at(plan_temp[$urandom_range(n - 1)]);
    if (roll < 95) return aim_at(plan_temp[0] - int'($urandom_range(3000)));
    return aim_at(plan_temp[n - 1] + int'($urandom_range(3000)));
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : sender
    fan_op_t op;
    logic    nx_start;
    logic    nx_we;
    nx_start = start;
    nx_we = 1'b0;
    if (rst) begin
      nx_start = 1'b0;
      quiet_cycles = 0;
      cal_gain = GAIN_RESET;
      cal_offset = OFFSET_RESET;
      active_points = COUNT_RESET;
    end else begin
      if (start && !busy) begin
        expected_lookups.push_back(lookup_duty(req_type, temperature, point_index,
                                               point_temp, point_duty));
        request_backlog.delete(0);
        nx_start = 1'b0;
      end
      if (expected_lookups.size() == 0 && !done && !busy && !nx_start)
        quiet_cycles++;
      else
        quiet_cycles = 0;
      if (!nx_start && request_backlog.size() != 0) begin
        op = request_backlog[0];
        case (op.kind)
          OP_WORD: begin
            if (op.eager || $urandom_range(99) >= 33) begin
              nx_start = 1'b1;
              req_type <= op.req;
              temperature <= op.temp;
              point_index <= op.idx;
              point_temp <= op.ptemp;
              point_duty <= op.pduty;
            end
          end
          OP_SETTING: begin
            if (quiet_cycles >= 2) begin
              nx_we = 1'b1;
              cfg_index <= op.reg_sel;
              cfg_data <= op.reg_val;
              store_setting(op.reg_sel, op.reg_val);
              setting_writes++;
              request_backlog.delete(0);
              quiet_cycles = 0;
            end
          end
          default: begin
            if (quiet_cycles >= 2) begin
              request_backlog.delete(0);
              quiet_cycles = 0;
            end
          end
        endcase
      end
    end
    start <= nx_start;
    cfg_we <= nx_we;
  end

  always @(posedge clk) begin : watcher
    fan_result_t want;
    if (!rst && done) begin
      if (expected_lookups.size() == 0) begin
        flag_error($sformatf("unexpected word duty=%0d cal=%0d seg=%0d status=%0d",
                             duty, calibrated_temp, segment, status));
      end else begin
        want = expected_lookups.pop_front();
        case (want.status)
          STATUS_WRITE: seen_writes++;
          STATUS_CLAMP: seen_clamped++;
          default:      seen_interp++;
        endcase
        if (duty !== want.duty || calibrated_temp !== want.cal ||
            segment !== want.seg || status !== want.status)
          flag_error($sformatf({"expected duty=%0d cal=%0d seg=%0d status=%0d, ",
                                "got duty=%0d cal=%0d seg=%0d status=%0d"},
                               want.duty, want.cal, want.seg, want.status,
                               duty, calibrated_temp, segment, status));
      end
    end
  end

  initial begin : stimulus
    int  phase, len, k, roll;
    longint base;
    int  pd;

    // directed: known curve, clamps, out-of-range counts, saturation
    queue_setting(CFG_UNUSED, 16'($urandom));
    for (k = 0; k < MAX_POINTS; k++)
      push_write(k, -5120 + k * 1280, (k == MAX_POINTS - 1) ? 32767 : k * 1600);
    push_sample(-16'sd32768);
    push_sample(16'sd0);
    queue_setting(CFG_COUNT, 16'd16);
    push_sample(-16'sd6000);
    push_sample(-16'sd5120);
    push_sample(16'sd640);
    push_sample(16'sd1280);
    push_sample(16'sd20000);
    queue_setting(CFG_COUNT, 16'd0);
    push_sample(16'sd0);
    queue_setting(CFG_COUNT, 16'd31);
    push_sample(16'sd20000);
    queue_setting(CFG_GAIN, 16'h8000);
    push_sample(-16'sd32768);
    queue_setting(CFG_GAIN, 16'h7FFF);
    push_sample(16'sd32767);
    push_sample(-16'sd32768);
    queue_setting(CFG_GAIN, 16'd4096);
    queue_setting(CFG_OFFSET, 16'h7FFF);
    push_sample(16'sd32767);
    queue_setting(CFG_OFFSET, 16'h8000);
    push_sample(-16'sd32768);
    queue_setting(CFG_OFFSET, 16'd0);
    push_write(0, -32768, 0);
    push_write(15, 32767, 25600);
    push_write(8, plan_temp[7], 12345);
    push_sample(-16'sd32768);
    push_sample(16'sd32767);
    push_sample(16'sd4500);

    // random phases of settings, curve loads and samples
    word_count = 0;
    phase = 0;
    while (word_count < RANDOM_WORDS) begin
      eager_mode = (phase == 2);
      roll = $urandom_range(99);
      queue_setting(CFG_GAIN, (roll < 60) ? 16'd4096 : (roll < 70) ? 16'h8000 :
                              (roll < 80) ? 16'h7FFF : 16'($urandom));
      roll = $urandom_range(99);
      queue_setting(CFG_OFFSET, (roll < 50) ? 16'd0 :
                                (roll < 80) ? 16'($urandom_range(4000)) - 16'd2000 :
                                (roll < 85) ? 16'h8000 : (roll < 90) ? 16'h7FFF :
                                16'($urandom));
      roll = $urandom_range(99);
      queue_setting(CFG_COUNT, (roll < 70) ? 16'($urandom_range(16, 2)) :
                               (roll < 80) ? 16'd1 : (roll < 90) ? 16'd0 :
                               16'($urandom_range(31, 17)));
      if (phase == 0 || $urandom_range(99) < 35) begin
        base = longint'($urandom_range(14000)) - 12000;
        for (k = 0; k < MAX_POINTS; k++) begin
          if (k > 0) base += ($urandom_range(9) == 0) ? 0 : 1 + $urandom_range(1999);
          pd = ($urandom_range(99) < 5) ? int'($urandom_range(32767)) :
                                          int'($urandom_range(25600));
          push_write(k, base, pd);
        end
      end
      len = 40 + $urandom_range(80);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(99) < 12) begin
          roll = $urandom_range(15);
          pd = ($urandom_range(99) < 8) ? int'($urandom_range(32767)) :
                                          int'($urandom_range(25600));
          if ($urandom_range(99) < 70)
            push_write(roll, plan_temp[roll] + int'($urandom_range(120)) - 60, pd);
          else
            push_write(roll, longint'($signed(16'($urandom))), pd);
        end else begin
          push_sample(pick_sample());
        end
        if ((phase == 4 && k == len / 2) || $urandom_range(199) == 0) queue_pause();
      end
      phase++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (request_backlog.size() != 0 || expected_lookups.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d point writes, %0d clamped and %0d interpolated samples,",
             seen_writes, seen_clamped, seen_interp);
    $display("%0d register writes over %0d random phases; %0d errors",
             setting_writes, phase, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
